[src/sha1_pkg.sv]
// sha1_pkg: types and constants shared by the sha-1 hash engine
// depends on nothing; imported by the channel interface and every module

package sha1_pkg;

   localparam int unsigned DIGEST_WORDS = 5;
   localparam int unsigned WINDOW_WORDS = 16;

   localparam logic [31:0] CHAIN_INIT [DIGEST_WORDS] = '{
      32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
   };

   localparam logic [31:0] ROUND_K0 = 32'h5A82_7999;
   localparam logic [31:0] ROUND_K1 = 32'h6ED9_EBA1;
   localparam logic [31:0] ROUND_K2 = 32'h8F1B_BCDC;
   localparam logic [31:0] ROUND_K3 = 32'hCA62_C1D6;

   // round counter bounds between the four round groups
   localparam logic [6:0] ROUND_GROUP1 = 7'd20;
   localparam logic [6:0] ROUND_GROUP2 = 7'd40;
   localparam logic [6:0] ROUND_GROUP3 = 7'd60;
   localparam logic [6:0] ROUND_LAST   = 7'd79;

   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam logic [5:0] LEN_POS    = 6'd56;
   localparam logic [5:0] BLOCK_LAST = 6'd63;
   localparam logic [2:0] WORD_LAST  = 3'd4;

   typedef enum logic [1:0] {
      SEL_MSG,
      SEL_MARK,
      SEL_ZERO,
      SEL_LEN
   } byte_sel_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       message_end;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef struct packed {
      logic         shift;
      byte_sel_type byte_sel;
      logic         count_inc;
      logic         round_init;
      logic         round_step;
      logic         chain_add;
      logic         out_next;
      logic         finish;
   } dp_cmd_type;

   typedef struct packed {
      logic pos_last;
      logic pos_len;
      logic round_last;
      logic out_last;
   } dp_status_type;

endpackage

[src/sha1_stream_if.sv]
// sha1_stream_if: valid/ready channel carrying one payload struct
// depends on sha1_pkg for the default payload type

interface sha1_stream_if import sha1_pkg::*; #(
   parameter type payload_type = req_type
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

[src/sha1_datapath.sv]
// sha1_datapath: block window, round logic, chaining value, length counter
// depends on sha1_pkg; driven by sha1_ctrl through dp_cmd_type

module sha1_datapath import sha1_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic [7:0]    data_byte,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output rsp_type       rsp_payload
);

   logic [31:0] window_ff [WINDOW_WORDS];
   logic [31:0] window_in [WINDOW_WORDS];
   logic [31:0] vars_ff [DIGEST_WORDS];
   logic [31:0] vars_in [DIGEST_WORDS];
   logic [31:0] chain_ff [DIGEST_WORDS];
   logic [31:0] chain_in [DIGEST_WORDS];
   logic [63:0] count_ff;
   logic [63:0] count_in;
   logic [5:0]  pos_ff;
   logic [5:0]  pos_in;
   logic [6:0]  round_ff;
   logic [6:0]  round_in;
   logic [2:0]  idx_ff;
   logic [2:0]  idx_in;

   logic [7:0]  pad_byte;
   logic [31:0] sched;
   logic [31:0] f_val;
   logic [31:0] k_val;
   logic [31:0] t_val;

   // byte entering the window
   always_comb begin
      unique case (cmd.byte_sel)
         SEL_MSG:  pad_byte = data_byte;
         SEL_MARK: pad_byte = PAD_MARK;
         SEL_ZERO: pad_byte = 8'h00;
         SEL_LEN:  pad_byte = count_ff[63:56];
         default:  pad_byte = 8'h00;
      endcase
   end

   // next schedule word from the rolling window
   assign sched = window_ff[13] ^ window_ff[8] ^ window_ff[2] ^ window_ff[0];

   always_comb begin
      priority if (round_ff < ROUND_GROUP1) begin
         f_val = (vars_ff[1] & vars_ff[2]) | (~vars_ff[1] & vars_ff[3]);
         k_val = ROUND_K0;
      end else if (round_ff < ROUND_GROUP2) begin
         f_val = vars_ff[1] ^ vars_ff[2] ^ vars_ff[3];
         k_val = ROUND_K1;
      end else if (round_ff < ROUND_GROUP3) begin
         f_val = (vars_ff[1] & vars_ff[2]) | (vars_ff[1] & vars_ff[3]) |
                 (vars_ff[2] & vars_ff[3]);
         k_val = ROUND_K2;
      end else begin
         f_val = vars_ff[1] ^ vars_ff[2] ^ vars_ff[3];
         k_val = ROUND_K3;
      end
   end

   assign t_val = {vars_ff[0][26:0], vars_ff[0][31:27]} + f_val + vars_ff[4] + k_val +
                  window_ff[0];

   // window: byte shift while loading, word shift while rounds run
   always_comb begin
      window_in = window_ff;
      if (cmd.shift) begin
         for (int i = 0; i < WINDOW_WORDS - 1; i++) begin
            window_in[i] = {window_ff[i][23:0], window_ff[i+1][31:24]};
         end
         window_in[WINDOW_WORDS-1] = {window_ff[WINDOW_WORDS-1][23:0], pad_byte};
      end else if (cmd.round_step) begin
         for (int i = 0; i < WINDOW_WORDS - 1; i++) begin
            window_in[i] = window_ff[i+1];
         end
         window_in[WINDOW_WORDS-1] = {sched[30:0], sched[31]};
      end
   end

   always_comb begin
      vars_in = vars_ff;
      if (cmd.round_init) begin
         vars_in = chain_ff;
      end else if (cmd.round_step) begin
         vars_in[0] = t_val;
         vars_in[1] = vars_ff[0];
         vars_in[2] = {vars_ff[1][1:0], vars_ff[1][31:2]};
         vars_in[3] = vars_ff[2];
         vars_in[4] = vars_ff[3];
      end
   end

   always_comb begin
      chain_in = chain_ff;
      if (cmd.finish) begin
         chain_in = CHAIN_INIT;
      end else if (cmd.chain_add) begin
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            chain_in[i] = chain_ff[i] + vars_ff[i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.finish) begin
         count_in = '0;
      end else if (cmd.count_inc) begin
         count_in = count_ff + 64'd8;
      end else if (cmd.shift && cmd.byte_sel == SEL_LEN) begin
         count_in = {count_ff[55:0], 8'h00};
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (cmd.finish) begin
         pos_in = '0;
      end else if (cmd.shift) begin
         pos_in = pos_ff + 6'd1;
      end
   end

   always_comb begin
      round_in = round_ff;
      if (cmd.round_init) begin
         round_in = '0;
      end else if (cmd.round_step) begin
         round_in = round_ff + 7'd1;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.finish) begin
         idx_in = '0;
      end else if (cmd.out_next) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      vars_ff   <= vars_in;
      round_ff  <= round_in;
      if (reset) begin
         chain_ff <= CHAIN_INIT;
         count_ff <= '0;
         pos_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         chain_ff <= chain_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
         idx_ff   <= idx_in;
      end
   end

   assign status.pos_last   = (pos_ff == BLOCK_LAST);
   assign status.pos_len    = (pos_ff == LEN_POS);
   assign status.round_last = (round_ff == ROUND_LAST);
   assign status.out_last   = (idx_ff == WORD_LAST);

   assign rsp_payload.digest_word = chain_ff[idx_ff];
   assign rsp_payload.word_index  = idx_ff;
   assign rsp_payload.last_word   = (idx_ff == WORD_LAST);

endmodule

[src/sha1_ctrl.sv]
// sha1_ctrl: sequencer for byte loading, padding, compression and digest output
// depends on sha1_pkg; commands sha1_datapath through dp_cmd_type

module sha1_ctrl import sha1_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          byte_present,
   input  logic          message_end,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INIT,
      S_ROUND,
      S_ADD,
      S_MARK,
      S_ZERO,
      S_LEN,
      S_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;
   state_type ret_ff;
   state_type ret_in;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      cmd      = '0;
      cmd.byte_sel = SEL_MSG;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (byte_present) begin
                  cmd.shift     = 1'b1;
                  cmd.count_inc = 1'b1;
               end
               if (byte_present && status.pos_last) begin
                  state_in = S_INIT;
                  ret_in   = message_end ? S_MARK : S_IDLE;
               end else if (message_end) begin
                  state_in = S_MARK;
               end
            end
         end
         S_INIT: begin
            cmd.round_init = 1'b1;
            state_in       = S_ROUND;
         end
         S_ROUND: begin
            cmd.round_step = 1'b1;
            if (status.round_last) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            cmd.chain_add = 1'b1;
            state_in      = ret_ff;
         end
         S_MARK: begin
            cmd.shift    = 1'b1;
            cmd.byte_sel = SEL_MARK;
            if (status.pos_last) begin
               state_in = S_INIT;
               ret_in   = S_ZERO;
            end else begin
               state_in = S_ZERO;
            end
         end
         S_ZERO: begin
            if (status.pos_len) begin
               state_in = S_LEN;
            end else begin
               cmd.shift    = 1'b1;
               cmd.byte_sel = SEL_ZERO;
               if (status.pos_last) begin
                  state_in = S_INIT;
                  ret_in   = S_ZERO;
               end
            end
         end
         S_LEN: begin
            cmd.shift    = 1'b1;
            cmd.byte_sel = SEL_LEN;
            if (status.pos_last) begin
               state_in = S_INIT;
               ret_in   = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               cmd.out_next = 1'b1;
               if (status.out_last) begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

endmodule

[src/sha1_hash_engine.sv]
// sha1_hash_engine: streaming sha-1 engine, bytes in, five digest words out
// depends on sha1_pkg, sha1_stream_if, sha1_ctrl and sha1_datapath
//
//   port     dir  payload                                   transaction
//   req_ch   in   data_byte, byte_present, message_end      one message byte and/or end mark
//   rsp_ch   out  digest_word, word_index, last_word        one 32-bit digest word
//
// message bytes are taken one per cycle while idle; the byte that fills a 64-byte block
// then starts the load, 80 rounds in the single round unit and the chaining add
// an end mark pads one byte per cycle up to offset 56 (held during compressions), then
// a turn state, 8 length bytes, one or two compressions, five words out while rsp_ch is ready
// synchronous active-high reset restores the initial chaining value and a zero length
// a stalled rsp_ch holds the current word; no request is taken until all five leave

module sha1_hash_engine import sha1_pkg::*; (
   input logic          clock,
   input logic          reset,
   sha1_stream_if.sink   req_ch,
   sha1_stream_if.source rsp_ch
);

   dp_cmd_type    cmd;
   dp_status_type status;
   rsp_type       rsp_payload;

   // controller: handshakes and sequencing of load, pad, rounds and output
   sha1_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_ch.valid),
      .byte_present (req_ch.payload.byte_present),
      .message_end  (req_ch.payload.message_end),
      .req_ready    (req_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .status       (status),
      .cmd          (cmd)
   );

   // datapath: message window, round unit, chaining value and bit length
   sha1_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .data_byte   (req_ch.payload.data_byte),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

   assign rsp_ch.payload = rsp_payload;

endmodule

[tb/sha1_digest_check.sv]
// sha1_digest_check: watches both channels of the sha-1 engine, predicts digests, compares
// depends on sha1_pkg for the payload structs and the sha-1 constants

module sha1_digest_check import sha1_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_payload,
   output int      fail_count,
   output int      outstanding
);

   logic [31:0] chain [DIGEST_WORDS];
   logic [7:0]  block_bytes [64];
   logic [63:0] msg_bits;
   rsp_type     expected_digest_words [$];
   int          errors = 0;

   assign fail_count = errors;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // one 80-round compression of block_bytes into chain
   function automatic void sha1_compress();
      logic [31:0] w [WINDOW_WORDS];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++)
         w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int r = 0; r < 80; r++) begin
         if (r >= 16)
            w[r % 16] = rotl(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16], 1);
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = ROUND_K0;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = ROUND_K1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = ROUND_K2;
         end else begin
            f = b ^ c ^ d;
            k = ROUND_K3;
         end
         t = rotl(a, 5) + f + e + k + w[r % 16];
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
   endfunction

   // take one request transaction, queue five digest words on an end mark
   function automatic void sha1_absorb(input req_type item);
      int      pos;
      rsp_type word;
      if (item.byte_present) begin
         pos = int'(msg_bits[8:3]);
         block_bytes[pos] = item.data_byte;
         msg_bits += 64'd8;
         if (pos == BLOCK_LAST)
            sha1_compress();
      end
      if (item.message_end) begin
         pos = int'(msg_bits[8:3]);
         block_bytes[pos] = PAD_MARK;
         for (int i = pos + 1; i < 64; i++)
            block_bytes[i] = 8'h00;
         // length no longer fits behind the mark
         if (pos + 1 > LEN_POS) begin
            sha1_compress();
            for (int i = 0; i < 64; i++)
               block_bytes[i] = 8'h00;
         end
         for (int i = 0; i < 8; i++)
            block_bytes[LEN_POS + i] = msg_bits[63 - 8*i -: 8];
         sha1_compress();
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            word.digest_word = chain[i];
            word.word_index  = 3'(i);
            word.last_word   = (3'(i) == WORD_LAST);
            expected_digest_words.push_back(word);
         end
         chain = CHAIN_INIT;
         msg_bits = '0;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         chain = CHAIN_INIT;
         msg_bits = '0;
         expected_digest_words.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_digest_words.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("check: unexpected digest word %h index %0d last %0d",
                           rsp_payload.digest_word, rsp_payload.word_index,
                           rsp_payload.last_word);
            end else begin
               want = expected_digest_words.pop_front();
               if (rsp_payload !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("check: digest mismatch expected %h/%0d/%0d actual %h/%0d/%0d",
                              want.digest_word, want.word_index, want.last_word,
                              rsp_payload.digest_word, rsp_payload.word_index,
                              rsp_payload.last_word);
               end
            end
         end
         if (req_valid && req_ready)
            sha1_absorb(req_payload);
         outstanding <= expected_digest_words.size();
      end
   end

endmodule

[tb/sha1_hash_engine_tb.sv]
// sha1_hash_engine_tb: stimulus and verdict for the streaming sha-1 engine
// depends on sha1_pkg, sha1_stream_if, sha1_hash_engine and sha1_digest_check

module sha1_hash_engine_tb import sha1_pkg::*; ();

   localparam int TARGET_ITEMS = 430;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int HOLD_CYCLES  = 600;   // long receiver stall, fills the engine
   localparam int DRAIN_CYCLES = 300;   // two compressions plus padding

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   items_sent = 0;
   int   fail_count;
   int   outstanding;
   bit   hold_rsp = 1'b0;

   sha1_stream_if #(.payload_type(req_type)) req_if ();
   sha1_stream_if #(.payload_type(rsp_type)) rsp_if ();

   sha1_hash_engine dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if.sink),
      .rsp_ch (rsp_if.source)
   );

   // predicts every digest and compares the rsp side
   sha1_digest_check digest_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_ready   (req_if.ready),
      .req_payload (req_if.payload),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_payload (rsp_if.payload),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // gap length: mostly none or short, now and then long
   function automatic int draw_gap(input bit steady);
      int roll;
      if (steady)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic req_type make_item(input logic [7:0] data, input logic present,
                                         input logic last);
      req_type item;
      item.data_byte    = data;
      item.byte_present = present;
      item.message_end  = last;
      return item;
   endfunction

   // offer one transaction, return at the edge that accepts it
   // valid stays high so a following item goes out back to back
   task automatic send_item(input req_type item);
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic pause(input int cycles);
      if (cycles > 0) begin
         req_if.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // sender stands still until every digest word has come out
   task automatic wait_digests_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // one message of random bytes, end mark either on the last byte or on its own
   task automatic send_message(input int len, input bit steady);
      req_type item;
      bit      joined;
      joined = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
         // occasional empty transaction, the engine ignores it
         if ($urandom_range(0, 19) == 0) begin
            send_item(make_item(8'($urandom), 1'b0, 1'b0));
            pause(draw_gap(steady));
         end
         item = make_item(8'($urandom), 1'b1, joined && (i == len - 1));
         send_item(item);
         items_sent++;
         pause(draw_gap(steady));
      end
      if (!joined) begin
         send_item(make_item(8'($urandom), 1'b0, 1'b1));
         items_sent++;
         pause(draw_gap(steady));
      end
   endtask

   // receiver: random ready pattern, one long hold-off on request
   initial begin
      int off_len;
      bit steady;
      bit hold_done;
      steady = 1'b0;
      hold_done = 1'b0;
      rsp_if.ready <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         if ($urandom_range(0, 29) == 0)
            steady = !steady;
         if (hold_rsp && !hold_done) begin
            off_len = HOLD_CYCLES;
            hold_done = 1'b1;
         end else begin
            off_len = draw_gap(steady);
         end
         if (off_len > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (off_len) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // sender: directed messages, then random ones, then verdict
   initial begin
      int len;
      int roll;
      bit steady;
      bit mid_drain_done;
      int boundary_len [8];
      boundary_len = '{55, 56, 57, 63, 64, 65, 119, 120};
      mid_drain_done = 1'b0;
      req_if.valid   <= 1'b0;
      req_if.payload <= make_item(8'h00, 1'b0, 1'b0);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      send_item(make_item(8'h00, 1'b0, 1'b0));   // neither byte nor end
      send_item(make_item(8'hFF, 1'b0, 1'b1));   // empty message
      send_item(make_item(8'hFF, 1'b1, 1'b1));   // one byte with the end mark
      pause(draw_gap(1'b0));
      send_item(make_item(8'h00, 1'b1, 1'b0));   // byte, then a bare end mark
      send_item(make_item(8'h00, 1'b0, 1'b1));
      send_item(make_item(8'h61, 1'b1, 1'b0));   // "abc"
      pause(draw_gap(1'b0));
      send_item(make_item(8'h62, 1'b1, 1'b0));
      send_item(make_item(8'h63, 1'b1, 1'b1));
      send_item(make_item(8'h80, 1'b1, 1'b0));   // top bit alone, then low bits
      send_item(make_item(8'h7F, 1'b1, 1'b1));
      items_sent = 9;
      wait_digests_drained();

      // receiver stalls for a long stretch while messages keep coming
      hold_rsp = 1'b1;

      // random part: mostly short messages, some around the block boundaries
      while (items_sent < TARGET_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 12)
            len = boundary_len[$urandom_range(0, 7)];
         else if (roll < 17)
            len = 0;
         else
            len = $urandom_range(1, 24);
         steady = ($urandom_range(0, 3) == 0);
         send_message(len, steady);
         if (!mid_drain_done && items_sent >= TARGET_ITEMS / 2) begin
            wait_digests_drained();
            mid_drain_done = 1'b1;
         end
      end

      wait_digests_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
